// ===== rtl/core/acl_pkg.sv =====
// Shared constants, codes and table entry types for the connection admission ACL.
// Used by the rule table, the slot table and the top level; depends on nothing.
package acl_pkg;

  localparam int RULE_COUNT = 16;
  localparam int SLOT_COUNT = 64;

  localparam int RULE_IW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam int RULE_CW = $clog2(RULE_COUNT + 1);
  localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_CW = $clog2(SLOT_COUNT + 1);
  localparam int CNT_W   = (SLOT_CW > 10) ? SLOT_CW : 10;

  localparam logic [6:0] SLOT_LIMIT_RST = 7'd64;

  localparam logic [1:0] KIND_RULE    = 2'd0;
  localparam logic [1:0] KIND_CONNECT = 2'd1;
  localparam logic [1:0] KIND_DISC    = 2'd2;

  localparam logic [1:0] ACT_ALLOW  = 2'd0;
  localparam logic [1:0] ACT_ALWAYS = 2'd1;
  localparam logic [1:0] ACT_DENY   = 2'd2;
  localparam logic [1:0] ACT_ERASE  = 2'd3;

  localparam logic [1:0] DEC_ALLOW  = 2'd0;
  localparam logic [1:0] DEC_ALWAYS = 2'd1;
  localparam logic [1:0] DEC_DENY   = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_DENIED  = 2'd1;
  localparam logic [1:0] ERR_LIMITED = 2'd2;
  localparam logic [1:0] ERR_INVALID = 2'd3;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] pat_hi;
    logic [63:0] pat_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic [1:0]  act;
    logic [9:0]  max_cnt;
  } rule_ent_t;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } slot_ent_t;

  typedef struct packed {
    logic               wr_en;
    logic               erase;
    logic [RULE_IW-1:0] addr;
    rule_ent_t          data;
  } rule_wr_t;

  typedef struct packed {
    logic               wr_en;
    logic               clr_en;
    logic [SLOT_IW-1:0] addr;
    slot_ent_t          data;
  } slot_wr_t;

  function automatic logic rule_hits(rule_ent_t r, logic v6, logic [63:0] hi,
                                     logic [63:0] lo);
    return (r.is_v6 == v6) && ((hi & r.mask_hi) == r.pat_hi) &&
           ((lo & r.mask_lo) == r.pat_lo);
  endfunction

endpackage

// ===== rtl/core/connection_admission_acl.sv =====
// A connect stops the rule scan at the first matching rule; an always or deny rule also
// skips the slot scan and ends the connect there.
// One item is processed at a time; the rule scan and slot scan read one memory entry per
// cycle. A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, rst_n low) clears rule valid bits, slot busy bits, the active count
// and sets slot_limit to 64; no clearing pass is needed.
module connection_admission_acl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data,   // slot_limit
  input  logic         in_tvalid,
  output logic         in_tready,
  // family[0], address_high[64:1], address_low[128:65], prefix_length[136:129],
  // rule_index[140:137], rule_action[142:141], rule_limit[152:143], slot_index[158:153]
  input  logic [159:0] in_tdata,
  input  logic [1:0]   in_tuser,      // kind[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // decision[1:0], error_code[3:2], granted_slot[9:4], matched[10], matched_rule[14:11]
  output logic [15:0]  out_tdata
);

  localparam int RIW = acl_pkg::RULE_IW;
  localparam int RCW = acl_pkg::RULE_CW;
  localparam int SIW = acl_pkg::SLOT_IW;
  localparam int SCW = acl_pkg::SLOT_CW;
  localparam int CW  = acl_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RULE_WR, S_RSCAN, S_SSCAN, S_SDEC, S_DISC_RD, S_DISC, S_DONE
  } state_t;

  state_t state_r;

  logic [6:0]  slot_limit_r;
  logic        fam_r;
  logic [63:0] hi_r, lo_r;
  logic [7:0]  plen_r;
  logic [3:0]  ridx_r;
  logic [1:0]  ract_r;
  logic [9:0]  rlim_r;
  logic [5:0]  sidx_r;

  logic [RCW-1:0] rcnt_r;
  logic           rpend_r;
  logic [RIW-1:0] rq_idx_r;
  logic [SCW-1:0] scnt_r;
  logic           spend_r;
  logic [SIW-1:0] sq_idx_r;
  logic [CW-1:0]  hit_cnt_r;
  logic           free_fnd_r;
  logic [SIW-1:0] free_idx_r;
  logic [SCW-1:0] active_cnt_r;

  logic           m_r;
  logic [RIW-1:0] mr_r;
  acl_pkg::rule_ent_t rule_r;

  logic [1:0] res_dec_r, res_err_r;
  logic [5:0] res_slot_r;
  logic       out_tvalid_r;
  logic [15:0] out_tdata_r;

  acl_pkg::rule_wr_t  rule_wr;
  acl_pkg::rule_ent_t rule_rd;
  logic               rule_rd_valid;
  acl_pkg::slot_wr_t  slot_wr;
  acl_pkg::slot_ent_t slot_rd;
  logic               slot_rd_busy;
  logic [SIW-1:0]     slot_rd_addr;

  logic [63:0] mask_hi, mask_lo;
  logic        bad_idx, erase, too_long;
  logic [CW-1:0] lim;
  logic        rule_hit, limited;
  logic        disc_ok;

  // Prefix masks for the rule being written.
  always_comb begin
    if (fam_r) begin
      mask_hi = (plen_r >= 8'd64) ? '1 : ~(64'hFFFF_FFFF_FFFF_FFFF >> plen_r);
      mask_lo = (plen_r <= 8'd64) ? '0 :
                ~(64'hFFFF_FFFF_FFFF_FFFF >> (plen_r - 8'd64));
    end else begin
      mask_hi = '0;
      mask_lo = {32'd0, ~(32'hFFFF_FFFF >> plen_r)};
    end
  end

  assign bad_idx  = int'(ridx_r) >= acl_pkg::RULE_COUNT;
  assign erase    = (ract_r == acl_pkg::ACT_ERASE);
  assign too_long = fam_r ? (plen_r > 8'd128) : (plen_r > 8'd32);

  always_comb begin
    rule_wr              = '0;
    rule_wr.wr_en        = (state_r == S_RULE_WR) && !bad_idx && (erase || !too_long);
    rule_wr.erase        = erase;
    rule_wr.addr         = RIW'(ridx_r);
    rule_wr.data.is_v6   = fam_r;
    rule_wr.data.mask_hi = mask_hi;
    rule_wr.data.mask_lo = mask_lo;
    rule_wr.data.pat_hi  = hi_r & mask_hi;
    rule_wr.data.pat_lo  = lo_r & mask_lo;
    rule_wr.data.act     = ract_r;
    rule_wr.data.max_cnt = rlim_r;
  end

  assign lim = (CW'(slot_limit_r) > CW'(acl_pkg::SLOT_COUNT)) ?
               CW'(acl_pkg::SLOT_COUNT) : CW'(slot_limit_r);

  assign rule_hit = rpend_r && rule_rd_valid &&
                    acl_pkg::rule_hits(rule_rd, fam_r, hi_r, lo_r);

  assign limited = (CW'(active_cnt_r) >= lim) ||
                   (m_r && (rule_r.max_cnt != 10'd0) && (hit_cnt_r >= CW'(rule_r.max_cnt))) ||
                   !free_fnd_r;

  assign disc_ok = int'(sidx_r) < acl_pkg::SLOT_COUNT;

  assign slot_rd_addr = (state_r == S_SSCAN) ? scnt_r[SIW-1:0] : SIW'(sidx_r);

  always_comb begin
    slot_wr              = '0;
    slot_wr.wr_en        = (state_r == S_SDEC) && !limited;
    slot_wr.clr_en       = (state_r == S_DISC) && disc_ok && slot_rd_busy;
    slot_wr.addr         = (state_r == S_SDEC) ? free_idx_r : SIW'(sidx_r);
    slot_wr.data.is_v6   = fam_r;
    slot_wr.data.addr_hi = hi_r;
    slot_wr.data.addr_lo = lo_r;
  end

  acl_rule_tbl u_rule_tbl (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_i       (rule_wr),
    .rd_addr_i  (rcnt_r[RIW-1:0]),
    .rd_data_o  (rule_rd),
    .rd_valid_o (rule_rd_valid)
  );

  acl_slot_tbl u_slot_tbl (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (slot_wr),
    .rd_addr_i (slot_rd_addr),
    .rd_data_o (slot_rd),
    .rd_busy_o (slot_rd_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_limit_r <= acl_pkg::SLOT_LIMIT_RST;
      active_cnt_r <= '0;
      out_tvalid_r <= 1'b0;
      rpend_r      <= 1'b0;
      spend_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slot_limit_r <= cfg_wr_data;
      end
      // In S_DONE the output register is reloaded below instead.
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            fam_r   <= in_tdata[0];
            hi_r    <= in_tdata[0] ? in_tdata[64:1] : 64'd0;
            lo_r    <= in_tdata[0] ? in_tdata[128:65] : {32'd0, in_tdata[96:65]};
            plen_r  <= in_tdata[136:129];
            ridx_r  <= in_tdata[140:137];
            ract_r  <= in_tdata[142:141];
            rlim_r  <= in_tdata[152:143];
            sidx_r  <= in_tdata[158:153];
            res_dec_r  <= acl_pkg::DEC_ALLOW;
            res_err_r  <= acl_pkg::ERR_NONE;
            res_slot_r <= '0;
            m_r        <= 1'b0;
            mr_r       <= '0;
            rcnt_r     <= '0;
            rpend_r    <= 1'b0;
            case (in_tuser)
              acl_pkg::KIND_RULE:    state_r <= S_RULE_WR;
              acl_pkg::KIND_CONNECT: state_r <= S_RSCAN;
              acl_pkg::KIND_DISC:    state_r <= S_DISC_RD;
              default:               state_r <= S_DONE;
            endcase
          end
        end

        S_RULE_WR: begin
          res_err_r <= (bad_idx || (!erase && too_long)) ?
                       acl_pkg::ERR_INVALID : acl_pkg::ERR_NONE;
          state_r   <= S_DONE;
        end

        // One rule read issued per cycle; the compare on its registered data follows in the next cycle.
        S_RSCAN: begin
          if (rcnt_r < RCW'(acl_pkg::RULE_COUNT)) begin
            rcnt_r   <= rcnt_r + RCW'(1);
            rq_idx_r <= rcnt_r[RIW-1:0];
            rpend_r  <= 1'b1;
          end else begin
            rpend_r <= 1'b0;
          end
          if (rule_hit || (rpend_r && rq_idx_r == RIW'(acl_pkg::RULE_COUNT - 1))) begin
            m_r        <= rule_hit;
            mr_r       <= rule_hit ? rq_idx_r : '0;
            rule_r     <= rule_rd;
            scnt_r     <= '0;
            spend_r    <= 1'b0;
            hit_cnt_r  <= '0;
            free_fnd_r <= 1'b0;
            free_idx_r <= '0;
            if (rule_hit && rule_rd.act == acl_pkg::ACT_ALWAYS) begin
              res_dec_r <= acl_pkg::DEC_ALWAYS;
              state_r   <= S_DONE;
            end else if (rule_hit && rule_rd.act == acl_pkg::ACT_DENY) begin
              res_dec_r <= acl_pkg::DEC_DENY;
              res_err_r <= acl_pkg::ERR_DENIED;
              state_r   <= S_DONE;
            end else begin
              state_r <= S_SSCAN;
            end
          end
        end

        // Counts busy slots matching the rule and finds the lowest usable free slot.
        S_SSCAN: begin
          if (scnt_r < SCW'(acl_pkg::SLOT_COUNT)) begin
            scnt_r   <= scnt_r + SCW'(1);
            sq_idx_r <= scnt_r[SIW-1:0];
            spend_r  <= 1'b1;
          end else begin
            spend_r <= 1'b0;
          end
          if (spend_r) begin
            if (slot_rd_busy && m_r &&
                acl_pkg::rule_hits(rule_r, slot_rd.is_v6, slot_rd.addr_hi,
                                   slot_rd.addr_lo)) begin
              hit_cnt_r <= hit_cnt_r + CW'(1);
            end
            if (!slot_rd_busy && !free_fnd_r && (CW'(sq_idx_r) < lim)) begin
              free_fnd_r <= 1'b1;
              free_idx_r <= sq_idx_r;
            end
            if (sq_idx_r == SIW'(acl_pkg::SLOT_COUNT - 1)) begin
              state_r <= S_SDEC;
            end
          end
        end

        S_SDEC: begin
          if (limited) begin
            res_dec_r <= acl_pkg::DEC_DENY;
            res_err_r <= acl_pkg::ERR_LIMITED;
          end else begin
            res_slot_r   <= 6'(free_idx_r);
            active_cnt_r <= active_cnt_r + SCW'(1);
          end
          state_r <= S_DONE;
        end

        S_DISC_RD: begin
          state_r <= S_DISC;
        end

        S_DISC: begin
          if (disc_ok && slot_rd_busy && active_cnt_r != '0) begin
            active_cnt_r <= active_cnt_r - SCW'(1);
          end
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, 4'(mr_r), m_r, res_slot_r, res_err_r, res_dec_r};
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(active_cnt_r) <= acl_pkg::SLOT_COUNT)
    else $error("active count above slot table size");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in work");

  a_limited_deny: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:2] == acl_pkg::ERR_LIMITED) |->
    out_tdata[1:0] == acl_pkg::DEC_DENY)
    else $error("limited result without deny decision");

  a_always_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == acl_pkg::DEC_ALWAYS) |->
    (out_tdata[3:2] == acl_pkg::ERR_NONE && out_tdata[10]))
    else $error("always decision without a clean rule match");
`endif

endmodule

// ===== rtl/core/acl_rule_tbl.sv =====
// Rule table: synchronous memory of prefix rules with one registered read port.
// Valid bits sit in flip-flops cleared at reset. Depends on acl_pkg.
module acl_rule_tbl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  acl_pkg::rule_wr_t           wr_i,
  input  logic [acl_pkg::RULE_IW-1:0] rd_addr_i,
  output acl_pkg::rule_ent_t          rd_data_o,
  output logic                        rd_valid_o
);

  acl_pkg::rule_ent_t mem_r [acl_pkg::RULE_COUNT];
  acl_pkg::rule_ent_t rd_data_r;
  logic [acl_pkg::RULE_COUNT-1:0] valid_r;
  logic rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_i.wr_en && !wr_i.erase) begin
      mem_r[wr_i.addr] <= wr_i.data;
    end
    rd_data_r <= mem_r[rd_addr_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_i.wr_en) begin
        valid_r[wr_i.addr] <= !wr_i.erase;
      end
      rd_valid_r <= valid_r[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_r;
  assign rd_valid_o = rd_valid_r;

endmodule

// ===== rtl/core/acl_slot_tbl.sv =====
// Slot table: synchronous memory of connection addresses with one registered read port.
// Busy bits sit in flip-flops cleared at reset. Depends on acl_pkg.
module acl_slot_tbl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  acl_pkg::slot_wr_t           wr_i,
  input  logic [acl_pkg::SLOT_IW-1:0] rd_addr_i,
  output acl_pkg::slot_ent_t          rd_data_o,
  output logic                        rd_busy_o
);

  acl_pkg::slot_ent_t mem_r [acl_pkg::SLOT_COUNT];
  acl_pkg::slot_ent_t rd_data_r;
  logic [acl_pkg::SLOT_COUNT-1:0] busy_r;
  logic rd_busy_r;

  always_ff @(posedge clk) begin
    if (wr_i.wr_en) begin
      mem_r[wr_i.addr] <= wr_i.data;
    end
    rd_data_r <= mem_r[rd_addr_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= '0;
      rd_busy_r <= 1'b0;
    end else begin
      if (wr_i.wr_en) begin
        busy_r[wr_i.addr] <= 1'b1;
      end else if (wr_i.clr_en) begin
        busy_r[wr_i.addr] <= 1'b0;
      end
      rd_busy_r <= busy_r[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_r;
  assign rd_busy_o = rd_busy_r;

endmodule
